// ----- rtl/rwl_pkg.sv -----
// Shared types, constants and codes of the readers-writer lock manager.
package rwl_pkg;

    localparam int NUM_SHARDS = 16;
    localparam int COUNT_BITS = 8;
    localparam int SHARD_W    = 4;
    localparam int ADDR_W     = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;

    typedef enum logic [1:0] {
        CMD_BEGIN_READ  = 2'd0,
        CMD_END_READ    = 2'd1,
        CMD_BEGIN_WRITE = 2'd2,
        CMD_END_WRITE   = 2'd3
    } rwl_cmd_t;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_ERROR    = 2'd3
    } rwl_status_t;

    typedef enum logic [1:0] {
        WAKE_NONE   = 2'd0,
        WAKE_READER = 2'd1,
        WAKE_WRITER = 2'd2
    } rwl_wake_t;

    typedef logic [COUNT_BITS-1:0] rwl_count_t;

    typedef struct packed {
        rwl_cmd_t           cmd;
        logic [SHARD_W-1:0] shard;
    } rwl_in_t;

    typedef struct packed {
        logic [SHARD_W-1:0] shard_out;
        rwl_status_t        status;
        rwl_wake_t          wake;
    } rwl_out_t;

    // One shard's lock state as kept in the RAM.
    typedef struct packed {
        rwl_count_t reader_count;
        logic       writer_active;
        rwl_count_t readers_waiting;
        rwl_count_t writers_waiting;
    } rwl_entry_t;

    localparam int ENTRY_W = $bits(rwl_entry_t);

    // Outcome of one lock command on one entry.
    typedef struct packed {
        rwl_entry_t  entry;
        logic        write;
        rwl_status_t status;
        rwl_wake_t   wake;
    } rwl_upd_t;

endpackage

// ----- rtl/rwl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/rwl_update.sv -----
// Lock command evaluation: next shard state, status and wake code.
module rwl_update (
    input  rwl_pkg::rwl_cmd_t   cmd,
    input  logic                shard_ok,
    input  rwl_pkg::rwl_entry_t entry,
    output rwl_pkg::rwl_upd_t   upd
);

    localparam rwl_pkg::rwl_count_t CNT_MAX = '1;
    localparam rwl_pkg::rwl_count_t CNT_ONE = rwl_pkg::rwl_count_t'(1);

    always_comb begin
        upd.entry  = entry;
        upd.status = rwl_pkg::ST_ERROR;
        upd.wake   = rwl_pkg::WAKE_NONE;
        if (shard_ok) begin
            case (cmd)
                rwl_pkg::CMD_BEGIN_READ: begin
                    if (entry.writer_active || entry.writers_waiting != '0) begin
                        if (entry.readers_waiting != CNT_MAX) begin
                            upd.entry.readers_waiting = entry.readers_waiting + CNT_ONE;
                            upd.status = rwl_pkg::ST_QUEUED;
                        end
                    end else if (entry.reader_count != CNT_MAX) begin
                        upd.entry.reader_count = entry.reader_count + CNT_ONE;
                        upd.status = rwl_pkg::ST_GRANTED;
                    end
                end
                rwl_pkg::CMD_END_READ: begin
                    if (entry.reader_count != '0) begin
                        upd.entry.reader_count = entry.reader_count - CNT_ONE;
                        // last reader out hands the lock to a waiting writer
                        if (entry.reader_count == CNT_ONE && entry.writers_waiting != '0) begin
                            upd.entry.writer_active   = 1'b1;
                            upd.entry.writers_waiting = entry.writers_waiting - CNT_ONE;
                            upd.wake = rwl_pkg::WAKE_WRITER;
                        end
                        upd.status = rwl_pkg::ST_RELEASED;
                    end
                end
                rwl_pkg::CMD_BEGIN_WRITE: begin
                    if (entry.writer_active || entry.reader_count != '0 ||
                        entry.readers_waiting != '0 || entry.writers_waiting != '0) begin
                        if (entry.writers_waiting != CNT_MAX) begin
                            upd.entry.writers_waiting = entry.writers_waiting + CNT_ONE;
                            upd.status = rwl_pkg::ST_QUEUED;
                        end
                    end else begin
                        upd.entry.writer_active = 1'b1;
                        upd.status = rwl_pkg::ST_GRANTED;
                    end
                end
                default: begin
                    if (entry.writer_active) begin
                        if (entry.readers_waiting != '0) begin
                            // readers take precedence after a write
                            if (entry.reader_count != CNT_MAX) begin
                                upd.entry.writer_active   = 1'b0;
                                upd.entry.reader_count    = entry.reader_count + CNT_ONE;
                                upd.entry.readers_waiting = entry.readers_waiting - CNT_ONE;
                                upd.wake   = rwl_pkg::WAKE_READER;
                                upd.status = rwl_pkg::ST_RELEASED;
                            end
                        end else if (entry.writers_waiting != '0) begin
                            upd.entry.writers_waiting = entry.writers_waiting - CNT_ONE;
                            upd.wake   = rwl_pkg::WAKE_WRITER;
                            upd.status = rwl_pkg::ST_RELEASED;
                        end else begin
                            upd.entry.writer_active = 1'b0;
                            upd.status = rwl_pkg::ST_RELEASED;
                        end
                    end
                end
            endcase
        end
        // errors leave the shard untouched
        upd.write = (upd.status != rwl_pkg::ST_ERROR);
    end

endmodule

// ----- rtl/readers_writer_lock_manager.sv -----
// Top level of the per-shard readers-writer lock manager.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  s_      | in  | s_valid / s_ready  | s_data: cmd, shard
//  m_      | out | m_valid / m_ready  | m_data: shard_out, status, wake
//
// Sustained rate is one item per cycle while m_ready stays high. An accepted item is
// registered in the update stage, and its result then loads into the output register
// that drives m_valid. This follows from the shard RAM's read-modify-write: read in
// the accept cycle, update and write back as the item leaves the update stage,
// with a forward register covering an item that hits the shard just written.
// Reset clears per-shard valid bits at once; an entry not yet written reads as
// zero, so no clearing pass is needed and items are taken right after reset.
// A stalled m_ready holds the item in the update stage and drops s_ready.
module readers_writer_lock_manager (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rwl_pkg::rwl_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rwl_pkg::rwl_out_t m_data
);

    localparam int AW = rwl_pkg::ADDR_W;

    // Update stage: the item whose entry read is in flight
    logic                       busy_reg, busy_next;
    rwl_pkg::rwl_in_t           item_reg;
    logic                       rd_vld_reg;
    logic                       fwd_hit_reg;
    rwl_pkg::rwl_entry_t        fwd_reg;

    // Output register
    logic                       m_valid_reg;
    rwl_pkg::rwl_out_t          m_data_reg;

    // Per-shard "written since reset" flags
    logic [rwl_pkg::NUM_SHARDS-1:0] vld_reg;

    logic                       accept;
    logic                       out_free;
    logic                       exec;
    logic [AW-1:0]              addr_in;
    logic [AW-1:0]              addr_cur;
    logic                       shard_ok;
    logic [rwl_pkg::ENTRY_W-1:0] rd_data;
    rwl_pkg::rwl_entry_t        entry_cur;
    rwl_pkg::rwl_upd_t          upd;

    assign out_free = !m_valid_reg || m_ready;
    assign exec     = busy_reg && out_free;
    assign s_ready  = !busy_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign addr_in  = AW'(s_data.shard);
    assign addr_cur = AW'(item_reg.shard);
    assign shard_ok = (32'(item_reg.shard) < rwl_pkg::NUM_SHARDS);

    // Pick the freshest copy of the entry: forwarded write, RAM, or reset value
    always_comb begin
        if (fwd_hit_reg) begin
            entry_cur = fwd_reg;
        end else if (rd_vld_reg) begin
            entry_cur = rwl_pkg::rwl_entry_t'(rd_data);
        end else begin
            entry_cur = '0;
        end
    end

    assign busy_next = accept ? 1'b1 : (exec ? 1'b0 : busy_reg);

    rwl_ram #(
        .WIDTH (rwl_pkg::ENTRY_W),
        .DEPTH (rwl_pkg::NUM_SHARDS)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (addr_in),
        .rd_data (rd_data),
        .wr_en   (exec && upd.write),
        .wr_addr (addr_cur),
        .wr_data (upd.entry)
    );

    rwl_update u_update (
        .cmd      (item_reg.cmd),
        .shard_ok (shard_ok),
        .entry    (entry_cur),
        .upd      (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            // Capture a new item and note whether it needs the entry written now
            if (accept) begin
                item_reg    <= s_data;
                rd_vld_reg  <= vld_reg[addr_in];
                fwd_hit_reg <= exec && upd.write && (addr_in == addr_cur);
                fwd_reg     <= upd.entry;
            end
            // Advance the update stage into the output register
            if (exec) begin
                m_valid_reg          <= 1'b1;
                m_data_reg.shard_out <= item_reg.shard;
                m_data_reg.status    <= upd.status;
                m_data_reg.wake      <= upd.wake;
                if (upd.write) begin
                    vld_reg[addr_cur] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/rwl_checker.sv -----
// Port-level assertions for the lock manager, bound to its top level.
module rwl_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input rwl_pkg::rwl_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input rwl_pkg::rwl_out_t m_data
);

    // A waiting item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("item changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result without an item accepted before it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without accepted item");

    // Only a release hands the lock to a waiter
    a_wake_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.wake != rwl_pkg::WAKE_NONE |-> m_data.status == rwl_pkg::ST_RELEASED)
        else $error("wake on a non-release result");

    // Input side accepts whenever the output register is empty
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind readers_writer_lock_manager rwl_checker u_rwl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/readers_writer_lock_manager_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the per-shard readers-writer lock manager.
module readers_writer_lock_manager_test;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    // Cycles with no item moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Idle cycles to wait after the last owed result is back, before closing out.
    localparam int DRAIN_PAD    = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int FREE_ITEMS   = 350;
    localparam int PLAN_ROWS    = 25;

    localparam rwl_pkg::rwl_count_t CNT_FULL = '1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One directed step; the typed result is used only when has_res is set.
    typedef struct {
        rwl_pkg::rwl_cmd_t    cmd;
        logic [3:0]           shard;
        bit                   has_res;
        rwl_pkg::rwl_status_t status;
        rwl_pkg::rwl_wake_t   wake;
    } plan_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rwl_pkg::rwl_in_t   s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rwl_pkg::rwl_out_t  m_data;

    // Lock state as this bench tracks it, one entry per shard.
    rwl_pkg::rwl_count_t readers_held   [rwl_pkg::NUM_SHARDS] = '{default: '0};
    logic                writer_held    [rwl_pkg::NUM_SHARDS] = '{default: 1'b0};
    rwl_pkg::rwl_count_t readers_parked [rwl_pkg::NUM_SHARDS] = '{default: '0};
    rwl_pkg::rwl_count_t writers_parked [rwl_pkg::NUM_SHARDS] = '{default: '0};

    // Lock results still owed by the block, oldest first.
    rwl_pkg::rwl_out_t lock_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int paced_items    = 0;
    int status_tally [4] = '{default: 0};
    int wake_tally   [3] = '{default: 0};

    // Directed steps: reset state, underflow on both ends, hand-over in every
    // direction, and a reader preferred over a writer when a write ends.
    plan_row_t lock_plan [PLAN_ROWS] = '{
        '{rwl_pkg::CMD_BEGIN_READ,  4'd0,  1'b1, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd0,  1'b1, rwl_pkg::ST_RELEASED, rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd0,  1'b1, rwl_pkg::ST_ERROR,    rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd15, 1'b1, rwl_pkg::ST_ERROR,    rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_WRITE, 4'd15, 1'b1, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_READ,  4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_WRITE, 4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_READ,  4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd15, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_READ,  4'd7,  1'b1, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_READ,  4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_WRITE, 4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_READ,  4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_READ,    4'd7,  1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_WRITE, 4'd10, 1'b1, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_BEGIN_WRITE, 4'd10, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd10, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd10, 1'b0, rwl_pkg::ST_GRANTED,  rwl_pkg::WAKE_NONE},
        '{rwl_pkg::CMD_END_WRITE,   4'd10, 1'b1, rwl_pkg::ST_ERROR,    rwl_pkg::WAKE_NONE}
    };

    readers_writer_lock_manager u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Apply one lock command to the tracked state and return the result it
    // must produce. An error leaves the shard untouched.
    function automatic rwl_pkg::rwl_out_t lock_outcome(input rwl_pkg::rwl_in_t req);
        rwl_pkg::rwl_out_t res;
        int                s;
        s             = int'(req.shard);
        res.shard_out = req.shard;
        res.status    = rwl_pkg::ST_ERROR;
        res.wake      = rwl_pkg::WAKE_NONE;
        if (s < rwl_pkg::NUM_SHARDS) begin
            case (req.cmd)
                rwl_pkg::CMD_BEGIN_READ: begin
                    // Park behind any writer, active or waiting.
                    if (writer_held[s] || writers_parked[s] != '0) begin
                        if (readers_parked[s] != CNT_FULL) begin
                            readers_parked[s] = readers_parked[s] + 1'b1;
                            res.status = rwl_pkg::ST_QUEUED;
                        end
                    end else if (readers_held[s] != CNT_FULL) begin
                        readers_held[s] = readers_held[s] + 1'b1;
                        res.status = rwl_pkg::ST_GRANTED;
                    end
                end
                rwl_pkg::CMD_END_READ: begin
                    if (readers_held[s] != '0) begin
                        readers_held[s] = readers_held[s] - 1'b1;
                        // Last reader out hands the lock to a waiting writer.
                        if (readers_held[s] == '0 && writers_parked[s] != '0) begin
                            writer_held[s]    = 1'b1;
                            writers_parked[s] = writers_parked[s] - 1'b1;
                            res.wake = rwl_pkg::WAKE_WRITER;
                        end
                        res.status = rwl_pkg::ST_RELEASED;
                    end
                end
                rwl_pkg::CMD_BEGIN_WRITE: begin
                    if (writer_held[s] || readers_held[s] != '0 ||
                        readers_parked[s] != '0 || writers_parked[s] != '0) begin
                        if (writers_parked[s] != CNT_FULL) begin
                            writers_parked[s] = writers_parked[s] + 1'b1;
                            res.status = rwl_pkg::ST_QUEUED;
                        end
                    end else begin
                        writer_held[s] = 1'b1;
                        res.status = rwl_pkg::ST_GRANTED;
                    end
                end
                default: begin
                    // End write: a waiting reader goes first, then a writer.
                    if (writer_held[s]) begin
                        if (readers_parked[s] != '0) begin
                            if (readers_held[s] != CNT_FULL) begin
                                writer_held[s]    = 1'b0;
                                readers_held[s]   = readers_held[s] + 1'b1;
                                readers_parked[s] = readers_parked[s] - 1'b1;
                                res.wake   = rwl_pkg::WAKE_READER;
                                res.status = rwl_pkg::ST_RELEASED;
                            end
                        end else if (writers_parked[s] != '0) begin
                            writers_parked[s] = writers_parked[s] - 1'b1;
                            res.wake   = rwl_pkg::WAKE_WRITER;
                            res.status = rwl_pkg::ST_RELEASED;
                        end else begin
                            writer_held[s] = 1'b0;
                            res.status = rwl_pkg::ST_RELEASED;
                        end
                    end
                end
            endcase
        end
        return res;
    endfunction

    // Mostly well-formed traffic on a few contended shards: ends only where a
    // holder exists. The rest is any command on any shard.
    function automatic rwl_pkg::rwl_in_t pick_request();
        rwl_pkg::rwl_in_t req;
        int               s;
        int               roll;
        s    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        roll = $urandom_range(0, 99);
        req.shard = 4'(s);
        if (roll < 12) begin
            req.cmd = rwl_pkg::rwl_cmd_t'($urandom_range(0, 3));
        end else if (readers_held[s] != '0 && roll < 45) begin
            req.cmd = rwl_pkg::CMD_END_READ;
        end else if (writer_held[s] && roll < 72) begin
            req.cmd = rwl_pkg::CMD_END_WRITE;
        end else begin
            req.cmd = ($urandom_range(0, 2) != 0) ? rwl_pkg::CMD_BEGIN_READ
                                                  : rwl_pkg::CMD_BEGIN_WRITE;
        end
        return req;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 68;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 68;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Offer one item, hold it until accepted, then queue what it must produce.
    // Called at a rising edge; each path drives s_valid once per step.
    task automatic send_request(input rwl_pkg::rwl_in_t req, input bit has_res,
                                input rwl_pkg::rwl_out_t fixed);
        rwl_pkg::rwl_out_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        want = lock_outcome(req);
        if (has_res) begin
            want = fixed;
        end
        lock_results.push_back(want);
        items_accepted++;
        status_tally[want.status]++;
        if (want.wake != rwl_pkg::WAKE_NONE) begin
            wake_tally[want.wake]++;
        end
    endtask

    // Rotate the idling pattern every phase of the paced bursts and the random part.
    task automatic send_paced(input rwl_pkg::rwl_in_t req);
        if (paced_items % PHASE_ITEMS == 0) begin
            set_idle(idle_mode_t'((paced_items / PHASE_ITEMS) % 4));
        end
        paced_items++;
        send_request(req, 1'b0, '0);
    endtask

    task automatic send_burst(input rwl_pkg::rwl_cmd_t cmd, input logic [3:0] shard,
                              input int count);
        rwl_pkg::rwl_in_t req;
        req.cmd   = cmd;
        req.shard = shard;
        repeat (count) send_paced(req);
    endtask

    // Hold the sender off until every owed result is back.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (lock_results.size() != 0);
    endtask

    // Result side: check each accepted result against the oldest one owed,
    // then draw the next ready.
    always @(posedge aclk) begin : result_check
        rwl_pkg::rwl_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (lock_results.size() == 0) begin
                $display("%0t ns: result with nothing owed: shard %0d status %0d wake %0d",
                         $time, m_data.shard_out, m_data.status, m_data.wake);
                errors++;
            end else begin
                want = lock_results.pop_front();
                if (m_data.shard_out !== want.shard_out) begin
                    $display("%0t ns: shard_out expected %0d actual %0d",
                             $time, want.shard_out, m_data.shard_out);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t ns: status (shard %0d) expected %0d actual %0d",
                             $time, want.shard_out, want.status, m_data.status);
                    errors++;
                end
                if (m_data.wake !== want.wake) begin
                    $display("%0t ns: wake (shard %0d) expected %0d actual %0d",
                             $time, want.shard_out, want.wake, m_data.wake);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Hang detector: count cycles in which no item moves on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no item moved for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, lock_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        rwl_pkg::rwl_in_t  req;
        rwl_pkg::rwl_out_t fixed;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed steps, no idling.
        set_idle(IDLE_NONE);
        for (int i = 0; i < PLAN_ROWS; i++) begin
            req.cmd         = lock_plan[i].cmd;
            req.shard       = lock_plan[i].shard;
            fixed.shard_out = lock_plan[i].shard;
            fixed.status    = lock_plan[i].status;
            fixed.wake      = lock_plan[i].wake;
            send_request(req, lock_plan[i].has_res, fixed);
        end
        wait_results_done();

        // Saturate every counter: active readers on shard 12, then both
        // waiting counts behind a writer on shard 13, with a hand-over after.
        send_burst(rwl_pkg::CMD_BEGIN_READ,  4'd12, 256);
        send_burst(rwl_pkg::CMD_END_READ,    4'd12, 1);
        send_burst(rwl_pkg::CMD_BEGIN_READ,  4'd12, 2);
        send_burst(rwl_pkg::CMD_BEGIN_WRITE, 4'd13, 1);
        send_burst(rwl_pkg::CMD_BEGIN_READ,  4'd13, 256);
        send_burst(rwl_pkg::CMD_BEGIN_WRITE, 4'd13, 256);
        send_burst(rwl_pkg::CMD_END_WRITE,   4'd13, 1);
        send_burst(rwl_pkg::CMD_BEGIN_READ,  4'd13, 2);
        wait_results_done();

        // Random traffic, idling pattern rotating per phase.
        repeat (FREE_ITEMS) send_paced(pick_request());

        set_idle(IDLE_NONE);
        wait_results_done();
        repeat (DRAIN_PAD) @(posedge aclk);

        if (lock_results.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, lock_results.size());
            errors++;
        end
        $display("Run: %0d lock commands, %0d results; granted %0d, queued %0d, released %0d",
                 items_accepted, results_seen, status_tally[rwl_pkg::ST_GRANTED],
                 status_tally[rwl_pkg::ST_QUEUED], status_tally[rwl_pkg::ST_RELEASED]);
        $display("     errors %0d, hand-overs to reader %0d, to writer %0d",
                 status_tally[rwl_pkg::ST_ERROR], wake_tally[rwl_pkg::WAKE_READER],
                 wake_tally[rwl_pkg::WAKE_WRITER]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rwl_pkg.sv
rtl/rwl_ram.sv
rtl/rwl_update.sv
rtl/readers_writer_lock_manager.sv
rtl/rwl_checker.sv
verif/readers_writer_lock_manager_test.sv
